FILE: hw/rtl/i2a_pkg.sv
`default_nettype none

package i2a_pkg;

   // Conversion modes carried on the request beat.
   typedef enum logic [1:0] {
      MODE_SDEC = 2'd0,
      MODE_UDEC = 2'd1,
      MODE_HEXL = 2'd2,
      MODE_HEXU = 2'd3
   } mode_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned DEC_W     = 32;
   localparam int unsigned BCD_DIGITS = 10;
   localparam int unsigned BCD_W     = 4 * BCD_DIGITS;
   localparam int unsigned HEX_DIGITS = VALUE_W / 4;
   localparam int unsigned NDIG_W    = $clog2(HEX_DIGITS + 1);
   localparam int unsigned STEP_W    = $clog2(DEC_W);
   localparam int unsigned COUNT_W   = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [7:0]         CHAR_ZERO  = 8'h30;
   localparam logic [7:0]         CHAR_MINUS = 8'h2d;
   localparam logic [7:0]         CHAR_LOWER = 8'h61;
   localparam logic [7:0]         CHAR_UPPER = 8'h41;

   // ASCII text of one nibble, in lower or upper case for the letters.
   function automatic logic [7:0] nibble_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      begin
         base = upper ? CHAR_UPPER : CHAR_LOWER;
         if (nib < 4'd10) begin
            nibble_char = CHAR_ZERO + {4'd0, nib};
         end else begin
            nibble_char = base + {4'd0, nib} - 8'd10;
         end
      end
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/i2a_dabble.sv
`default_nettype none

// One step of the shift-and-add-3 binary to BCD conversion.
module i2a_dabble (
   input  wire logic [i2a_pkg::BCD_W-1:0] bcd_cur,
   input  wire logic                      bin_msb,
   output logic      [i2a_pkg::BCD_W-1:0] bcd_next
);
   import i2a_pkg::*;

   logic [BCD_W-1:0] adjusted;

   // Every digit of five or more is corrected before the shift.
   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (bcd_cur[4*d +: 4] >= 4'd5) begin
            adjusted[4*d +: 4] = bcd_cur[4*d +: 4] + 4'd3;
         end else begin
            adjusted[4*d +: 4] = bcd_cur[4*d +: 4];
         end
      end
   end

   assign bcd_next = {adjusted[BCD_W-2:0], bin_msb};

endmodule

`default_nettype wire

FILE: hw/rtl/integer_to_ascii_digits_unit.sv
`default_nettype none

// Converts one integer per request beat into its ASCII digits, most
// significant first and without leading zeros, one character per response
// beat with a last flag and a saturating count of characters sent since
// reset. Signed decimal prefixes a minus sign to a negative value. The block
// takes one request at a time and is not ready until the last character has
// been taken. A hex request loads the value, drops each suppressed leading
// zero, finds the first digit and then delivers its characters. A decimal
// request loads the value and runs the bit-serial binary to BCD shifter,
// after which the same nibble shifter drops leading zeros, finds the first
// digit and delivers the remaining BCD digits, after the minus sign if any.
module integer_to_ascii_digits_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_mode,
   input  wire logic [i2a_pkg::VALUE_W-1:0]    req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [7:0]                     rsp_char_out,
   output logic                                rsp_last,
   output logic      [i2a_pkg::COUNT_W-1:0]    rsp_running_count
);
   import i2a_pkg::*;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   work_ff, work_in;
   logic [DEC_W-1:0]     bin_ff, bin_in;
   logic [NDIG_W-1:0]    ndig_ff, ndig_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 neg_ff, neg_in;
   logic                 upper_ff, upper_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 req_fire;
   logic                 rsp_fire;
   logic [DEC_W-1:0]     dec_low;
   logic                 dec_neg;
   logic [BCD_W-1:0]     bcd_next;
   logic [3:0]           top_nib;
   logic                 skip_more;
   logic [COUNT_W-1:0]   count_next;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign dec_low   = req_value[DEC_W-1:0];
   assign dec_neg   = (mode_type'(req_mode) == MODE_SDEC) && dec_low[DEC_W-1];
   assign top_nib   = work_ff[VALUE_W-1 -: 4];
   assign skip_more = (ndig_ff > NDIG_W'(1)) && (top_nib == 4'd0);
   assign count_next = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + COUNT_W'(1);

   // Shared BCD step works on the top of the nibble shifter.
   i2a_dabble u_dabble (
      .bcd_cur  (work_ff[VALUE_W-1 -: BCD_W]),
      .bin_msb  (bin_ff[DEC_W-1]),
      .bcd_next (bcd_next)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = req_mode[1] ? ST_SKIP : ST_DABBLE;
            end
         end
         ST_DABBLE: begin
            if (step_ff == STEP_W'(DEC_W - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!skip_more) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (rsp_fire) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (rsp_fire && (ndig_ff == NDIG_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and response payload.
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid    = (state_ff == ST_SIGN) || (state_ff == ST_DIGIT);
      rsp_char_out = (state_ff == ST_SIGN) ? CHAR_MINUS : nibble_char(top_nib, upper_ff);
      rsp_last     = (state_ff == ST_DIGIT) && (ndig_ff == NDIG_W'(1));
      rsp_running_count = count_next;
   end

   // Datapath next values.
   always_comb begin
      work_in  = work_ff;
      bin_in   = bin_ff;
      ndig_in  = ndig_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      upper_in = upper_ff;
      count_in = rsp_fire ? count_next : count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               upper_in = (mode_type'(req_mode) == MODE_HEXU);
               step_in  = '0;
               neg_in   = dec_neg;
               if (req_mode[1]) begin
                  work_in = req_value;
                  ndig_in = NDIG_W'(HEX_DIGITS);
               end else begin
                  work_in = '0;
                  bin_in  = dec_neg ? (~dec_low + DEC_W'(1)) : dec_low;
                  ndig_in = NDIG_W'(BCD_DIGITS);
               end
            end
         end
         ST_DABBLE: begin
            work_in[VALUE_W-1 -: BCD_W] = bcd_next;
            bin_in  = {bin_ff[DEC_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
         end
         ST_SKIP: begin
            if (skip_more) begin
               work_in = {work_ff[VALUE_W-5:0], 4'd0};
               ndig_in = ndig_ff - NDIG_W'(1);
            end
         end
         ST_DIGIT: begin
            if (rsp_fire) begin
               work_in = {work_ff[VALUE_W-5:0], 4'd0};
               ndig_in = ndig_ff - NDIG_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      bin_ff   <= bin_in;
      ndig_ff  <= ndig_in;
      step_ff  <= step_in;
      neg_ff   <= neg_in;
      upper_ff <= upper_in;
   end

   // A new request is never taken while a conversion is under way.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while busy");

   // The digit count is never exhausted while characters are being sent.
   a_ndig_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ndig_ff != '0))
      else $error("no digits left during response");

   // Each delivered beat advances the count unless it has saturated.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> (count_ff == $past(count_next)))
      else $error("character count did not advance");

   // The last flag never accompanies the minus sign.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> !rsp_last)
      else $error("minus sign flagged last");

endmodule

`default_nettype wire
